[rtl/hsl_pixel_colour_with_borders_core_defines.svh]
// Assertion macros shared by the pixel colour core.
`ifndef HSL_PIXEL_COLOUR_WITH_BORDERS_CORE_DEFINES_SVH
`define HSL_PIXEL_COLOUR_WITH_BORDERS_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that ante implies cons in the same cycle.
`define HSLPCB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that cond never holds.
`define HSLPCB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`else

`define HSLPCB_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define HSLPCB_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[rtl/hslpcb_pkg.sv]
// Types and constants shared by the pixel colour core.
package hslpcb_pkg;

  localparam int HueBits      = 16;
  localparam int RegionBits   = 20;
  localparam int SizeBits     = 20;
  localparam int FracBits     = 8;
  localparam int ChanBits     = 8;
  localparam int ChromaBits   = 2 * FracBits;
  localparam int NumBits      = ChromaBits + 1;
  localparam int RampBits     = HueBits + 1;
  localparam int SixBits      = HueBits + 3;
  localparam int ProdBits     = ChromaBits + RampBits;
  localparam int CfgIdxBits   = 1;
  localparam int CfgDataBits  = 20;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = $clog2(QueueDepth);

  localparam logic [SizeBits-1:0] MinRegionSizeReset = SizeBits'(5);
  localparam logic [ChanBits-1:0] ChanMax            = {ChanBits{1'b1}};

  typedef enum logic [CfgIdxBits-1:0] {
    CfgBordersEnabled = 1'b0,
    CfgMinRegionSize  = 1'b1
  } cfg_idx_e;

  // Hue sector, named after where the sector starts.
  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } sector_e;

  typedef struct packed {
    logic [HueBits-1:0]    hue;
    logic [FracBits-1:0]   saturation;
    logic [FracBits-1:0]   lightness;
    logic [RegionBits-1:0] own_region;
    logic [RegionBits-1:0] left_region;
    logic [RegionBits-1:0] right_region;
    logic [RegionBits-1:0] up_region;
    logic [RegionBits-1:0] down_region;
    logic                  at_frame_edge;
    logic [SizeBits-1:0]   smallest_region_size;
  } in_t;

  typedef struct packed {
    logic [ChanBits-1:0] red;
    logic [ChanBits-1:0] green;
    logic [ChanBits-1:0] blue;
    logic                is_border;
  } out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                  is_border;
    sector_e               sector;
    logic [ChromaBits-1:0] chroma;
    logic [NumBits-1:0]    base;
    logic [RampBits-1:0]   ramp;
  } work_t;

endpackage

[rtl/hsl_pixel_colour_with_borders_core.sv]
// Top level of the HSL pixel colour core with region borders.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per picture
// cell, carrying hue, saturation, lightness, the five region identifiers,
// the frame-edge flag and the smallest region size.
// Output channel (out_valid_o / out_stall_i / out_data_o): one beat per input
// beat, in order: red, green, blue and the border flag.
// Configuration: cfg_we_i writes cfg_wdata_i into the register picked by
// cfg_idx_i (borders enable, minimum region size); write only when idle.
// Path: a beat accepted into the front queue is registered in the multiply
// stage and then in the output register before it appears on the output.
// Throughput: one beat per cycle, limited by the single ramp multiplier and
// the output register; both take a new beat every cycle unless stalled.
// Stall: when out_stall_i holds, the output register and the multiply stage
// hold their beats and the four-entry queue keeps absorbing input; in_stall_o
// rises only once that queue is full and drops as soon as the output drains.
// Reset: rst_ni clears the queue and the stage valids and sets borders on
// with a minimum region size of five; payload registers are not cleared.
`include "hsl_pixel_colour_with_borders_core_defines.svh"

module hsl_pixel_colour_with_borders_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hslpcb_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [hslpcb_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  hslpcb_pkg::in_t                     in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hslpcb_pkg::out_t                    out_data_o
);

  hslpcb_pkg::work_t front_work;
  hslpcb_pkg::work_t q_head;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              push;

  // Take a beat whenever the queue has room.
  assign in_stall_o = q_full;
  assign push       = in_valid_i && !q_full;

  hslpcb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .work_o      (front_work)
  );

  hslpcb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_work),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  hslpcb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A full queue means the back end is backed up to the output.
  `HSLPCB_ASSERT_IMPLY(a_full_implies_out_valid, clk_i, rst_ni, in_stall_o, out_valid_o, "queue full while output empty")
  // Input stall only starts after a stalled output beat.
  `HSLPCB_ASSERT_IMPLY(a_stall_rise_cause, clk_i, rst_ni, $rose(in_stall_o), $past(out_valid_o && out_stall_i), "input stall without output stall")
  // Border beats are black.
  `HSLPCB_ASSERT_NEVER(a_border_black, clk_i, rst_ni, out_valid_o && out_data_o.is_border && ((out_data_o.red | out_data_o.green | out_data_o.blue) != '0), "border beat not black")

endmodule

[rtl/hslpcb_front.sv]
// Front end: configuration registers, border decision and hue/chroma terms.
module hslpcb_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hslpcb_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [hslpcb_pkg::CfgDataBits-1:0]  cfg_wdata_i,
  input  hslpcb_pkg::in_t                     in_data_i,
  output hslpcb_pkg::work_t                   work_o
);

  logic                                 borders_en_q;
  logic [hslpcb_pkg::SizeBits-1:0]      min_size_q;

  logic                                 higher;
  logic [hslpcb_pkg::FracBits:0]        twol;
  logic [hslpcb_pkg::FracBits:0]        dl;
  logic [hslpcb_pkg::FracBits-1:0]      span;
  logic [hslpcb_pkg::ChromaBits-1:0]    chroma;
  logic [hslpcb_pkg::NumBits-1:0]       light510;
  logic [hslpcb_pkg::SixBits-1:0]       six;
  logic [hslpcb_pkg::RampBits-1:0]      frac;
  logic [hslpcb_pkg::RampBits-1:0]      one;
  logic [hslpcb_pkg::RampBits-1:0]      ramp_gap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borders_en_q <= 1'b1;
      min_size_q   <= hslpcb_pkg::MinRegionSizeReset;
    end else if (cfg_we_i) begin
      unique case (hslpcb_pkg::cfg_idx_e'(cfg_idx_i))
        hslpcb_pkg::CfgBordersEnabled: borders_en_q <= cfg_wdata_i[0];
        hslpcb_pkg::CfgMinRegionSize:  min_size_q <= cfg_wdata_i[hslpcb_pkg::SizeBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    higher = (in_data_i.own_region > in_data_i.left_region)
          || (in_data_i.own_region > in_data_i.right_region)
          || (in_data_i.own_region > in_data_i.up_region)
          || (in_data_i.own_region > in_data_i.down_region);

    // Chroma scaled by 255*255: (255 - |2L - 255|) * S.
    twol   = {in_data_i.lightness, 1'b0};
    dl     = (twol >= {1'b0, hslpcb_pkg::ChanMax}) ? twol - {1'b0, hslpcb_pkg::ChanMax}
                                                  : {1'b0, hslpcb_pkg::ChanMax} - twol;
    span   = hslpcb_pkg::ChanMax - dl[hslpcb_pkg::FracBits-1:0];
    chroma = {{hslpcb_pkg::FracBits{1'b0}}, span}
           * {{hslpcb_pkg::FracBits{1'b0}}, in_data_i.saturation};

    // 510*L as 512*L - 2*L.
    light510 = {in_data_i.lightness, 9'b0}
             - {{(hslpcb_pkg::NumBits-hslpcb_pkg::FracBits-1){1'b0}}, in_data_i.lightness, 1'b0};

    // 6*hue: sector in the top bits, ramp from the low HueBits+1 bits.
    six      = {1'b0, in_data_i.hue, 2'b00} + {2'b00, in_data_i.hue, 1'b0};
    frac     = six[hslpcb_pkg::HueBits:0];
    one      = {1'b1, {hslpcb_pkg::HueBits{1'b0}}};
    ramp_gap = (frac >= one) ? frac - one : one - frac;

    work_o.is_border = borders_en_q && !in_data_i.at_frame_edge && higher
                    && (in_data_i.smallest_region_size > min_size_q);
    work_o.sector    = hslpcb_pkg::sector_e'(six[hslpcb_pkg::SixBits-1 -: 3]);
    work_o.chroma    = chroma;
    work_o.base      = light510 - {1'b0, chroma};
    work_o.ramp      = one - ramp_gap;
  end

endmodule

[rtl/hslpcb_queue.sv]
// Short queue decoupling the front end from the back end.
module hslpcb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hslpcb_pkg::work_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output hslpcb_pkg::work_t data_o
);

  hslpcb_pkg::work_t                     mem_q [hslpcb_pkg::QueueDepth];
  logic [hslpcb_pkg::QueuePtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [hslpcb_pkg::QueuePtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [hslpcb_pkg::QueuePtrBits:0]     count_q, count_d;

  always_comb begin
    full_o   = (count_q == (hslpcb_pkg::QueuePtrBits+1)'(hslpcb_pkg::QueueDepth));
    valid_o  = (count_q != '0);
    data_o   = mem_q[rd_ptr_q];
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[rtl/hslpcb_back.sv]
// Back end: ramp multiply, channel scaling and output register.
module hslpcb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  hslpcb_pkg::work_t q_data_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hslpcb_pkg::out_t  out_data_o
);

  // floor(n / 510) = floor(floor(n/2) / 255), the latter as (x + 1 + x>>8) >> 8.
  function automatic logic [hslpcb_pkg::ChanBits-1:0] to_chan(
    input logic [hslpcb_pkg::NumBits-1:0] n
  );
    logic [hslpcb_pkg::NumBits-2:0] half;
    logic [hslpcb_pkg::NumBits-1:0] acc;
    logic [hslpcb_pkg::ChanBits:0]  quo;
    half = n[hslpcb_pkg::NumBits-1:1];
    acc  = {1'b0, half}
         + hslpcb_pkg::NumBits'(half[hslpcb_pkg::NumBits-2:hslpcb_pkg::ChanBits])
         + hslpcb_pkg::NumBits'(1);
    quo  = acc[hslpcb_pkg::NumBits-1:hslpcb_pkg::ChanBits];
    return quo[hslpcb_pkg::ChanBits] ? hslpcb_pkg::ChanMax : quo[hslpcb_pkg::ChanBits-1:0];
  endfunction

  logic                                s1_valid_q;
  logic                                s1_border_q;
  hslpcb_pkg::sector_e                 s1_sector_q;
  logic [hslpcb_pkg::ChromaBits-1:0]   s1_chroma_q;
  logic [hslpcb_pkg::NumBits-1:0]      s1_base_q;
  logic [hslpcb_pkg::NumBits-1:0]      s1_y_q;

  logic                                out_valid_q;
  hslpcb_pkg::out_t                    out_data_q, out_data_d;

  logic                                s1_ready;
  logic                                s2_ready;
  logic [hslpcb_pkg::ProdBits-1:0]     prod;
  logic [hslpcb_pkg::NumBits-1:0]      hi_n, mid_n, lo_n;
  logic [hslpcb_pkg::ChanBits-1:0]     hi_c, mid_c, lo_c;

  always_comb begin
    s2_ready = !out_valid_q || !out_stall_i;
    s1_ready = !s1_valid_q || s2_ready;
    q_pop_o  = q_valid_i && s1_ready;
    prod     = hslpcb_pkg::ProdBits'(q_data_i.chroma) * hslpcb_pkg::ProdBits'(q_data_i.ramp);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage one: register the chroma*ramp product scaled down by 2^(HueBits-1).
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_border_q <= q_data_i.is_border;
      s1_sector_q <= q_data_i.sector;
      s1_chroma_q <= q_data_i.chroma;
      s1_base_q   <= q_data_i.base;
      s1_y_q      <= prod[hslpcb_pkg::HueBits-1 +: hslpcb_pkg::NumBits];
    end
  end

  // Stage two: form the three channel levels and route them by sector.
  always_comb begin
    hi_n  = s1_base_q + {s1_chroma_q, 1'b0};
    mid_n = s1_base_q + s1_y_q;
    lo_n  = s1_base_q;
    hi_c  = to_chan(hi_n);
    mid_c = to_chan(mid_n);
    lo_c  = to_chan(lo_n);

    out_data_d.is_border = 1'b0;
    unique case (s1_sector_q)
      hslpcb_pkg::SecRed:     begin out_data_d.red = hi_c;  out_data_d.green = mid_c; out_data_d.blue = lo_c;  end
      hslpcb_pkg::SecYellow:  begin out_data_d.red = mid_c; out_data_d.green = hi_c;  out_data_d.blue = lo_c;  end
      hslpcb_pkg::SecGreen:   begin out_data_d.red = lo_c;  out_data_d.green = hi_c;  out_data_d.blue = mid_c; end
      hslpcb_pkg::SecCyan:    begin out_data_d.red = lo_c;  out_data_d.green = mid_c; out_data_d.blue = hi_c;  end
      hslpcb_pkg::SecBlue:    begin out_data_d.red = mid_c; out_data_d.green = lo_c;  out_data_d.blue = hi_c;  end
      default:                begin out_data_d.red = hi_c;  out_data_d.green = lo_c;  out_data_d.blue = mid_c; end
    endcase

    // Force black on a border.
    if (s1_border_q) begin
      out_data_d = '{red: '0, green: '0, blue: '0, is_border: 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
